>>> design/mixed_width_register_alu_exec_unit_macros.svh
// Assertion macros shared by the execution unit's RTL files.
`ifndef MIXED_WIDTH_REGISTER_ALU_EXEC_UNIT_MACROS_SVH
`define MIXED_WIDTH_REGISTER_ALU_EXEC_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MWR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mwr_pkg.sv
// Types, codes and decode helpers for the mixed-width register execution unit.
package mwr_pkg;

  // Operation codes of the instruction word.
  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_ADD = 2'd1,
    CMD_SUB = 2'd2,
    CMD_JNZ = 2'd3
  } cmd_e;

  // Register classes after decode of a 4-bit register code.
  typedef enum logic [1:0] {
    RK_PC     = 2'd0,
    RK_NARROW = 2'd1,
    RK_WIDE   = 2'd2,
    RK_NONE   = 2'd3
  } reg_kind_e;

  // Register code map.
  localparam logic [3:0] RegCodePc       = 4'd0;
  localparam logic [3:0] RegCodeNarrowLo = 4'd1;
  localparam logic [3:0] RegCodeNarrowHi = 4'd4;
  localparam logic [3:0] RegCodeWideLo   = 4'd5;
  localparam logic [3:0] RegCodeWideHi   = 4'd10;

  localparam int NumNarrow = 4;
  localparam int NumWide   = 6;
  localparam int NarrowW   = 8;
  localparam int WordW     = 32;
  localparam int RegIdxW   = $clog2(NumWide);

  // Stream word widths.
  localparam int InDataW  = 48;
  localparam int OutDataW = 72;

  // Queue between decode and execute.
  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QLevelW = $clog2(QDepth + 1);

  typedef struct packed {
    reg_kind_e            kind;
    logic [RegIdxW-1:0]   idx;
  } reg_sel_t;

  // Decoded instruction as it travels through the queue.
  typedef struct packed {
    cmd_e              cmd;
    reg_sel_t          dst;
    reg_sel_t          src;
    logic [WordW-1:0]  imm;
  } uop_t;

  // Maps a register code to its class and index within that class.
  function automatic reg_sel_t decode_reg(input logic [3:0] code);
    reg_sel_t sel;
    logic [3:0] rel;
    sel.kind = RK_NONE;
    sel.idx  = '0;
    rel      = '0;
    if (code == RegCodePc) begin
      sel.kind = RK_PC;
    end else if (code >= RegCodeNarrowLo && code <= RegCodeNarrowHi) begin
      rel      = code - RegCodeNarrowLo;
      sel.kind = RK_NARROW;
      sel.idx  = rel[RegIdxW-1:0];
    end else if (code >= RegCodeWideLo && code <= RegCodeWideHi) begin
      rel      = code - RegCodeWideLo;
      sel.kind = RK_WIDE;
      sel.idx  = rel[RegIdxW-1:0];
    end
    return sel;
  endfunction

endpackage

>>> design/mwr_front.sv
// Front end: unpacks the incoming instruction word and decodes its register codes.
module mwr_front (
  input  logic [mwr_pkg::InDataW-1:0] in_data_i,
  output mwr_pkg::uop_t               uop_o
);

  // Field positions in the input word, lowest bit first.
  logic [1:0]  cmd_raw;
  logic [3:0]  dst_raw;
  logic [3:0]  src_raw;
  logic [31:0] imm_raw;

  assign cmd_raw = in_data_i[1:0];
  assign dst_raw = in_data_i[5:2];
  assign src_raw = in_data_i[9:6];
  assign imm_raw = in_data_i[41:10];

  // Classify both register operands.
  always_comb begin
    uop_o.cmd = mwr_pkg::cmd_e'(cmd_raw);
    uop_o.dst = mwr_pkg::decode_reg(dst_raw);
    uop_o.src = mwr_pkg::decode_reg(src_raw);
    uop_o.imm = imm_raw;
  end

endmodule

>>> design/mwr_queue.sv
// Short queue of decoded instructions between the front and back ends.
module mwr_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  mwr_pkg::uop_t                 push_uop_i,
  output logic                          full_o,
  input  logic                          pop_i,
  output logic                          valid_o,
  output mwr_pkg::uop_t                 pop_uop_o,
  output logic [mwr_pkg::QLevelW-1:0]   level_o
);

  mwr_pkg::uop_t                 mem_q [mwr_pkg::QDepth];
  logic [mwr_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [mwr_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [mwr_pkg::QLevelW-1:0]   level_q, level_d;

  assign full_o    = (level_q == mwr_pkg::QLevelW'(mwr_pkg::QDepth));
  assign valid_o   = (level_q != '0);
  assign pop_uop_o = mem_q[rd_ptr_q];
  assign level_o   = level_q;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mwr_pkg::QPtrW'(mwr_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mwr_pkg::QPtrW'(mwr_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_uop_i;
    end
  end

endmodule

>>> design/mwr_back.sv
// Back end: register file, execution of one instruction per cycle unless the output stalls, and output register.
module mwr_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           uop_valid_i,
  input  mwr_pkg::uop_t                  uop_i,
  output logic                           uop_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mwr_pkg::OutDataW-1:0]   out_data_o
);

  localparam int WordW   = mwr_pkg::WordW;
  localparam int NarrowW = mwr_pkg::NarrowW;

  logic [WordW-1:0]                         pc_q, pc_d;
  logic [mwr_pkg::NumNarrow-1:0][NarrowW-1:0] narrow_q;
  logic [mwr_pkg::NumWide-1:0][WordW-1:0]     wide_q;

  logic             out_valid_q;
  logic [WordW-1:0] out_pc_q, out_dest_q;
  logic             out_taken_q;

  logic             fire;
  logic [WordW-1:0] dst_val, src_val, result, dest_after;
  logic             is_jump, taken;

  // Reads one operand from the register file, narrow values zero-extended.
  function automatic logic [WordW-1:0] read_reg(
    input mwr_pkg::reg_sel_t                         sel,
    input logic [WordW-1:0]                          pc,
    input logic [mwr_pkg::NumNarrow-1:0][NarrowW-1:0] nar,
    input logic [mwr_pkg::NumWide-1:0][WordW-1:0]     wid
  );
    logic [WordW-1:0] val;
    val = '0;
    unique case (sel.kind)
      mwr_pkg::RK_PC:     val = pc;
      mwr_pkg::RK_NARROW: val = {{(WordW-NarrowW){1'b0}}, nar[sel.idx[1:0]]};
      mwr_pkg::RK_WIDE:   val = wid[sel.idx];
      default:            val = '0;
    endcase
    return val;
  endfunction

  assign uop_ready_o = !out_valid_q || out_ready_i;
  assign fire        = uop_valid_i && uop_ready_o;

  // Operand read and ALU.
  always_comb begin
    dst_val = read_reg(uop_i.dst, pc_q, narrow_q, wide_q);
    src_val = read_reg(uop_i.src, pc_q, narrow_q, wide_q);
    is_jump = (uop_i.cmd == mwr_pkg::CMD_JNZ);
    taken   = is_jump && (dst_val != '0);
    unique case (uop_i.cmd)
      mwr_pkg::CMD_SET: result = uop_i.imm;
      mwr_pkg::CMD_ADD: result = dst_val + src_val;
      mwr_pkg::CMD_SUB: result = dst_val - src_val;
      default:          result = dst_val;
    endcase
  end

  // Next program counter: a non-jump that wrote the counter still increments it.
  always_comb begin
    if (taken) begin
      pc_d = uop_i.imm;
    end else if (!is_jump && uop_i.dst.kind == mwr_pkg::RK_PC) begin
      pc_d = result + 1'b1;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // Destination value as seen after the instruction.
  always_comb begin
    unique case (uop_i.dst.kind)
      mwr_pkg::RK_PC:     dest_after = pc_d;
      mwr_pkg::RK_NARROW: dest_after = is_jump ? dst_val
                                               : {{(WordW-NarrowW){1'b0}}, result[NarrowW-1:0]};
      mwr_pkg::RK_WIDE:   dest_after = is_jump ? dst_val : result;
      default:            dest_after = '0;
    endcase
  end

  // Architectural register file update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      narrow_q <= '0;
      wide_q   <= '0;
    end else if (fire) begin
      pc_q <= pc_d;
      if (!is_jump && uop_i.dst.kind == mwr_pkg::RK_NARROW) begin
        narrow_q[uop_i.dst.idx[1:0]] <= result[NarrowW-1:0];
      end
      if (!is_jump && uop_i.dst.kind == mwr_pkg::RK_WIDE) begin
        wide_q[uop_i.dst.idx] <= result;
      end
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uop_ready_o) begin
      out_valid_q <= uop_valid_i;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pc_q    <= pc_d;
      out_dest_q  <= dest_after;
      out_taken_q <= taken;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(mwr_pkg::OutDataW-2*WordW-1){1'b0}}, out_taken_q, out_dest_q, out_pc_q};

endmodule

>>> design/mixed_width_register_alu_exec_unit.sv
// Top level of the mixed-width register execution unit.
//
//   Channel   Dir  Word layout (low bit first)
//   s_axis    in   cmd[1:0] dest_reg[5:2] src_reg[9:6] imm_value[41:10], zero pad to 48
//   m_axis    out  pc_after[31:0] dest_value[63:32] branch_taken[64], zero pad to 72
//
// One instruction per cycle is sustained while the output is not stalled; each
// word passes through the queue entry, then the execute stage with its output register.
// The register file read, ALU add or subtract and write-back all happen within the execute stage.
// Reset clears the program counter, all registers, the queue and the output flag.
// A stalled output holds its word while the two-entry queue keeps taking input until it is full.
`include "mixed_width_register_alu_exec_unit_macros.svh"

module mixed_width_register_alu_exec_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cmd, dest_reg, src_reg, imm_value
  input  logic [mwr_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pc_after, dest_value, branch_taken
  output logic [mwr_pkg::OutDataW-1:0]   m_axis_tdata
);

  mwr_pkg::uop_t                 dec_uop;
  mwr_pkg::uop_t                 q_uop;
  logic                          q_full, q_valid, q_pop, push;
  logic                          back_ready;
  logic [mwr_pkg::QLevelW-1:0]   q_level;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;
  assign q_pop         = q_valid && back_ready;

  mwr_front u_front (
    .in_data_i (s_axis_tdata),
    .uop_o     (dec_uop)
  );

  mwr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_uop_i (dec_uop),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_uop_o  (q_uop),
    .level_o    (q_level)
  );

  mwr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_valid_i (q_valid),
    .uop_i       (q_uop),
    .uop_ready_o (back_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // Queue fill never exceeds its depth.
  `MWR_ASSERT_IMPLY(a_q_level, clk_i, rst_ni, 1'b1, q_level <= mwr_pkg::QLevelW'(mwr_pkg::QDepth), "queue level above depth")

  // A word taken with nothing new entering execute leaves the output empty.
  `MWR_ASSERT_NEXT(a_out_drain, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !q_pop, !m_axis_tvalid, "output word repeated")

  // A popped instruction always shows up at the output next cycle.
  `MWR_ASSERT_NEXT(a_pop_out, clk_i, rst_ni, q_pop, m_axis_tvalid, "executed instruction lost")

endmodule
